// ----- sv/qsm_pkg.sv -----
// ----------------------------------------------------------------------------
// qsm_pkg: shared types and arithmetic for the quaternion/scale to matrix unit
// Fixed-point widths, rounding constants and the small helper functions
// used by the pipeline stages.
// ----------------------------------------------------------------------------
package qsm_pkg;

    // Field widths
    localparam int QUAT_W  = 16;   // Q2.14
    localparam int SCALE_W = 16;   // Q8.8
    localparam int TRANS_W = 32;   // Q16.16
    localparam int OUT_W   = 32;   // Q16.16

    // Internal widths
    localparam int PROD_W  = 2 * QUAT_W;          // a*b, units of 2^-28
    localparam int TERM_W  = PROD_W + 2;          // 1 - (2ab + 2cd), units of 2^-28
    localparam int SPROD_W = TERM_W + SCALE_W;    // term * scale, units of 2^-36
    localparam int DROP_W  = 20;                  // 2^-36 -> 2^-16

    localparam logic signed [TERM_W-1:0]  ONE_Q28   = TERM_W'(64'sd268435456);
    localparam logic signed [SPROD_W-1:0] HALF_DROP = SPROD_W'(64'sd524288);
    localparam logic signed [SPROD_W-1:0] Q16_MAX   = SPROD_W'(64'sd2147483647);
    localparam logic signed [SPROD_W-1:0] Q16_MIN   = SPROD_W'(-64'sd2147483648);

    // Product of two Q2.14 components
    typedef struct packed {
        logic signed [PROD_W-1:0] xx;
        logic signed [PROD_W-1:0] yy;
        logic signed [PROD_W-1:0] zz;
        logic signed [PROD_W-1:0] xy;
        logic signed [PROD_W-1:0] xz;
        logic signed [PROD_W-1:0] yz;
        logic signed [PROD_W-1:0] wx;
        logic signed [PROD_W-1:0] wy;
        logic signed [PROD_W-1:0] wz;
    } quat_prod_t;

    // Per-axis scales
    typedef struct packed {
        logic signed [SCALE_W-1:0] sx;
        logic signed [SCALE_W-1:0] sy;
        logic signed [SCALE_W-1:0] sz;
    } scale_t;

    // Translation row
    typedef struct packed {
        logic signed [TRANS_W-1:0] tx;
        logic signed [TRANS_W-1:0] ty;
        logic signed [TRANS_W-1:0] tz;
    } trans_t;

    typedef logic signed [TERM_W-1:0]  term_arr_t  [9];
    typedef logic signed [SPROD_W-1:0] sprod_arr_t [9];

    // Signed 16x16 product
    function automatic logic signed [PROD_W-1:0] mul_quat(
        input logic signed [QUAT_W-1:0] a,
        input logic signed [QUAT_W-1:0] b
    );
        mul_quat = PROD_W'(a) * PROD_W'(b);
    endfunction

    // Doubled product widened to term width
    function automatic logic signed [TERM_W-1:0] dbl(
        input logic signed [PROD_W-1:0] p
    );
        dbl = TERM_W'(p) <<< 1;
    endfunction

    // Round to nearest (ties up), drop fraction bits, clamp to Q16.16
    function automatic logic signed [OUT_W-1:0] round_sat(
        input logic signed [SPROD_W-1:0] p
    );
        logic signed [SPROD_W-1:0] rnd;
        logic signed [SPROD_W-1:0] sh;
        rnd = p + HALF_DROP;
        sh  = rnd >>> DROP_W;
        if (sh > Q16_MAX)
            round_sat = OUT_W'(Q16_MAX);
        else if (sh < Q16_MIN)
            round_sat = OUT_W'(Q16_MIN);
        else
            round_sat = OUT_W'(sh);
    endfunction

endpackage

// ----- sv/quaternion_scale_to_matrix_unit.sv -----
// ----------------------------------------------------------------------------
// quaternion_scale_to_matrix_unit
// Turns a Q2.14 quaternion, Q16.16 translation and Q8.8 per-axis scale into
// the upper three columns of a row-major 4x4 affine transform.
// ----------------------------------------------------------------------------
// A user of this block sees a four-stage pipeline that accepts one transform
// per clock while the output side is ready and returns results in order.
// Stage 1 forms the nine quaternion products (16x16 multipliers), stage 2 the
// doubled sums and the diagonal terms, stage 3 multiplies each term by its row
// scale (34x16 multipliers), and stage 4 rounds to Q16.16 with saturation into
// the output register. Every stage holds its own valid bit; a stall on the
// output backs up through the stages without losing or repeating a transfer,
// and empty stages keep filling while the output waits. Translation rides
// along unchanged. Rows 1..3 of the result are scaled by scale_x, scale_y and
// scale_z respectively; the constant column (0,0,0,1) is not output.
module quaternion_scale_to_matrix_unit
    import qsm_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [QUAT_W-1:0]   quat_x,
    input  logic signed [QUAT_W-1:0]   quat_y,
    input  logic signed [QUAT_W-1:0]   quat_z,
    input  logic signed [QUAT_W-1:0]   quat_w,
    input  logic signed [TRANS_W-1:0]  trans_x,
    input  logic signed [TRANS_W-1:0]  trans_y,
    input  logic signed [TRANS_W-1:0]  trans_z,
    input  logic signed [SCALE_W-1:0]  scale_x,
    input  logic signed [SCALE_W-1:0]  scale_y,
    input  logic signed [SCALE_W-1:0]  scale_z,

    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [OUT_W-1:0]    m_11,
    output logic signed [OUT_W-1:0]    m_12,
    output logic signed [OUT_W-1:0]    m_13,
    output logic signed [OUT_W-1:0]    m_21,
    output logic signed [OUT_W-1:0]    m_22,
    output logic signed [OUT_W-1:0]    m_23,
    output logic signed [OUT_W-1:0]    m_31,
    output logic signed [OUT_W-1:0]    m_32,
    output logic signed [OUT_W-1:0]    m_33,
    output logic signed [TRANS_W-1:0]  out_tx,
    output logic signed [TRANS_W-1:0]  out_ty,
    output logic signed [TRANS_W-1:0]  out_tz
);

    // Stage valid bits
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic s3_valid_reg;
    logic s4_valid_reg;

    // Stage load enables
    logic s1_load;
    logic s2_load;
    logic s3_load;
    logic s4_load;

    // Stage 1 payload
    quat_prod_t prod_reg;
    quat_prod_t prod_next;
    scale_t     s1_scale_reg;
    trans_t     s1_trans_reg;

    // Stage 2 payload
    term_arr_t  term_reg;
    term_arr_t  term_next;
    scale_t     s2_scale_reg;
    trans_t     s2_trans_reg;

    // Stage 3 payload
    sprod_arr_t sprod_reg;
    sprod_arr_t sprod_next;
    trans_t     s3_trans_reg;

    // Stage 4 payload (output register)
    logic signed [OUT_W-1:0] mat_reg  [9];
    logic signed [OUT_W-1:0] mat_next [9];
    trans_t                  s4_trans_reg;

    // Ready chain: a stage loads when it is empty or its contents move on
    assign s4_load  = !s4_valid_reg || out_ready;
    assign s3_load  = !s3_valid_reg || s4_load;
    assign s2_load  = !s2_valid_reg || s3_load;
    assign s1_load  = !s1_valid_reg || s2_load;
    assign in_ready = s1_load;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s2_load)
                s2_valid_reg <= s1_valid_reg;
            if (s3_load)
                s3_valid_reg <= s2_valid_reg;
            if (s4_load)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage 1: quaternion products
    always_comb
    begin
        prod_next.xx = mul_quat(quat_x, quat_x);
        prod_next.yy = mul_quat(quat_y, quat_y);
        prod_next.zz = mul_quat(quat_z, quat_z);
        prod_next.xy = mul_quat(quat_x, quat_y);
        prod_next.xz = mul_quat(quat_x, quat_z);
        prod_next.yz = mul_quat(quat_y, quat_z);
        prod_next.wx = mul_quat(quat_w, quat_x);
        prod_next.wy = mul_quat(quat_w, quat_y);
        prod_next.wz = mul_quat(quat_w, quat_z);
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            prod_reg        <= prod_next;
            s1_scale_reg.sx <= scale_x;
            s1_scale_reg.sy <= scale_y;
            s1_scale_reg.sz <= scale_z;
            s1_trans_reg.tx <= trans_x;
            s1_trans_reg.ty <= trans_y;
            s1_trans_reg.tz <= trans_z;
        end
    end

    // Stage 2: doubled sums and diagonal terms, row-major order
    always_comb
    begin
        term_next[0] = ONE_Q28 - (dbl(prod_reg.yy) + dbl(prod_reg.zz));
        term_next[1] = dbl(prod_reg.xy) + dbl(prod_reg.wz);
        term_next[2] = dbl(prod_reg.xz) - dbl(prod_reg.wy);
        term_next[3] = dbl(prod_reg.xy) - dbl(prod_reg.wz);
        term_next[4] = ONE_Q28 - (dbl(prod_reg.xx) + dbl(prod_reg.zz));
        term_next[5] = dbl(prod_reg.yz) + dbl(prod_reg.wx);
        term_next[6] = dbl(prod_reg.xz) + dbl(prod_reg.wy);
        term_next[7] = dbl(prod_reg.yz) - dbl(prod_reg.wx);
        term_next[8] = ONE_Q28 - (dbl(prod_reg.xx) + dbl(prod_reg.yy));
    end

    always_ff @(posedge clk)
    begin
        if (s2_load && s1_valid_reg)
        begin
            term_reg     <= term_next;
            s2_scale_reg <= s1_scale_reg;
            s2_trans_reg <= s1_trans_reg;
        end
    end

    // Stage 3: scale each row by its axis scale
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            if (i < 3)
                sprod_next[i] = SPROD_W'(term_reg[i]) * SPROD_W'(s2_scale_reg.sx);
            else if (i < 6)
                sprod_next[i] = SPROD_W'(term_reg[i]) * SPROD_W'(s2_scale_reg.sy);
            else
                sprod_next[i] = SPROD_W'(term_reg[i]) * SPROD_W'(s2_scale_reg.sz);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_load && s2_valid_reg)
        begin
            sprod_reg    <= sprod_next;
            s3_trans_reg <= s2_trans_reg;
        end
    end

    // Stage 4: round to Q16.16 and clamp
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            mat_next[i] = round_sat(sprod_reg[i]);
    end

    always_ff @(posedge clk)
    begin
        if (s4_load && s3_valid_reg)
        begin
            mat_reg      <= mat_next;
            s4_trans_reg <= s3_trans_reg;
        end
    end

    // Drive outputs
    assign out_valid = s4_valid_reg;
    assign m_11      = mat_reg[0];
    assign m_12      = mat_reg[1];
    assign m_13      = mat_reg[2];
    assign m_21      = mat_reg[3];
    assign m_22      = mat_reg[4];
    assign m_23      = mat_reg[5];
    assign m_31      = mat_reg[6];
    assign m_32      = mat_reg[7];
    assign m_33      = mat_reg[8];
    assign out_tx    = s4_trans_reg.tx;
    assign out_ty    = s4_trans_reg.ty;
    assign out_tz    = s4_trans_reg.tz;

`ifndef NO_ASSERTIONS
    // An empty or draining output stage must let the input side transfer
    a_ready_when_draining: assert property (
        @(posedge clk) disable iff (!rst_n)
        (!out_valid || out_ready) |-> in_ready
    ) else $error("input stalled while the output stage could move");

    // A new result can only come from an occupied stage 3
    a_out_from_stage3: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(s3_valid_reg)
    ) else $error("result appeared without an item in stage 3");

    // A stalled full pipeline must not take new input
    a_full_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && s4_valid_reg && !out_ready)
            |-> !in_ready
    ) else $error("input accepted while every stage is full and stalled");
`endif

endmodule

// ----- sim/quaternion_scale_to_matrix_unit_tb.sv -----
// ----------------------------------------------------------------------------
// quaternion_scale_to_matrix_unit_tb: self-checking bench for the pose unit
// Feeds quaternion, translation and scale transfers through the valid/ready
// input, computes the scaled rotation rows and the translation row in a local
// model, and compares every output transfer field by field, in order, while
// both sides idle at random.
// ----------------------------------------------------------------------------
module quaternion_scale_to_matrix_unit_tb;

    import qsm_pkg::*;

    localparam int CYCLE_LIMIT = 60000;
    localparam int RAND_POSES  = 1250;
    localparam int IDLE_PCT    = 24;
    localparam int QUIET_LO    = 600;
    localparam int QUIET_HI    = 900;
    localparam int DRAIN_WAIT  = 12;

    // One input transfer; hold makes the sender wait until all results are back
    typedef struct {
        logic [QUAT_W-1:0]  qx;
        logic [QUAT_W-1:0]  qy;
        logic [QUAT_W-1:0]  qz;
        logic [QUAT_W-1:0]  qw;
        logic [TRANS_W-1:0] tx;
        logic [TRANS_W-1:0] ty;
        logic [TRANS_W-1:0] tz;
        logic [SCALE_W-1:0] sx;
        logic [SCALE_W-1:0] sy;
        logic [SCALE_W-1:0] sz;
        logic               hold;
    } pose_t;

    // One output transfer
    typedef struct {
        logic [OUT_W-1:0]   m11, m12, m13;
        logic [OUT_W-1:0]   m21, m22, m23;
        logic [OUT_W-1:0]   m31, m32, m33;
        logic [TRANS_W-1:0] tx, ty, tz;
    } xform_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [QUAT_W-1:0]   quat_x   = '0;
    logic signed [QUAT_W-1:0]   quat_y   = '0;
    logic signed [QUAT_W-1:0]   quat_z   = '0;
    logic signed [QUAT_W-1:0]   quat_w   = '0;
    logic signed [TRANS_W-1:0]  trans_x  = '0;
    logic signed [TRANS_W-1:0]  trans_y  = '0;
    logic signed [TRANS_W-1:0]  trans_z  = '0;
    logic signed [SCALE_W-1:0]  scale_x  = '0;
    logic signed [SCALE_W-1:0]  scale_y  = '0;
    logic signed [SCALE_W-1:0]  scale_z  = '0;

    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [OUT_W-1:0]    m_11, m_12, m_13;
    logic signed [OUT_W-1:0]    m_21, m_22, m_23;
    logic signed [OUT_W-1:0]    m_31, m_32, m_33;
    logic signed [TRANS_W-1:0]  out_tx, out_ty, out_tz;

    pose_t  pose_q[$];
    xform_t xform_q[$];
    pose_t  cur_pose;
    xform_t want;
    int     sent_cnt  = 0;
    int     got_cnt   = 0;
    int     err_cnt   = 0;
    int     cycle_cnt = 0;

    quaternion_scale_to_matrix_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .trans_x   (trans_x),
        .trans_y   (trans_y),
        .trans_z   (trans_z),
        .scale_x   (scale_x),
        .scale_y   (scale_y),
        .scale_z   (scale_z),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .m_11      (m_11),
        .m_12      (m_12),
        .m_13      (m_13),
        .m_21      (m_21),
        .m_22      (m_22),
        .m_23      (m_23),
        .m_31      (m_31),
        .m_32      (m_32),
        .m_33      (m_33),
        .out_tx    (out_tx),
        .out_ty    (out_ty),
        .out_tz    (out_tz)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // Scale a Q28 term by a Q8.8 scale, round half up to Q16.16, clamp
    function automatic logic [OUT_W-1:0] scale_to_q16(longint term, longint scale);
        longint acc;
        acc = term * scale + (longint'(1) <<< 19);
        acc = acc >>> 20;
        if (acc > longint'(32'sh7FFFFFFF))
            acc = longint'(32'sh7FFFFFFF);
        else if (acc < -longint'(64'sd2147483648))
            acc = -longint'(64'sd2147483648);
        return acc[OUT_W-1:0];
    endfunction

    // Build the scaled rotation rows and the translation row of one pose
    function automatic xform_t pose_to_xform(pose_t p);
        longint x, y, z, w, sx, sy, sz, one;
        longint xx2, yy2, zz2, xy2, xz2, yz2, wx2, wy2, wz2;
        xform_t r;
        x   = longint'($signed(p.qx));
        y   = longint'($signed(p.qy));
        z   = longint'($signed(p.qz));
        w   = longint'($signed(p.qw));
        sx  = longint'($signed(p.sx));
        sy  = longint'($signed(p.sy));
        sz  = longint'($signed(p.sz));
        one = longint'(1) <<< 28;
        xx2 = 2 * x * x;
        yy2 = 2 * y * y;
        zz2 = 2 * z * z;
        xy2 = 2 * x * y;
        xz2 = 2 * x * z;
        yz2 = 2 * y * z;
        wx2 = 2 * w * x;
        wy2 = 2 * w * y;
        wz2 = 2 * w * z;
        r.m11 = scale_to_q16(one - (yy2 + zz2), sx);
        r.m12 = scale_to_q16(xy2 + wz2, sx);
        r.m13 = scale_to_q16(xz2 - wy2, sx);
        r.m21 = scale_to_q16(xy2 - wz2, sy);
        r.m22 = scale_to_q16(one - (xx2 + zz2), sy);
        r.m23 = scale_to_q16(yz2 + wx2, sy);
        r.m31 = scale_to_q16(xz2 + wy2, sz);
        r.m32 = scale_to_q16(yz2 - wx2, sz);
        r.m33 = scale_to_q16(one - (xx2 + yy2), sz);
        r.tx  = p.tx;
        r.ty  = p.ty;
        r.tz  = p.tz;
        return r;
    endfunction

    // Random 16-bit field, biased toward extremes, powers of two and small values
    function automatic logic [15:0] pick16();
        int unsigned sel;
        logic [15:0] v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = 16'h8000;
            1: v = 16'h7FFF;
            2:
            begin
                v = 16'(1) << $urandom_range(0, 14);
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
            3: v = 16'($signed($urandom_range(0, 511)) - 256);
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick32();
        int unsigned sel;
        logic [31:0] v;
        sel = $urandom_range(0, 9);
        case (sel)
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic add_pose(
        input logic [15:0] qx, input logic [15:0] qy,
        input logic [15:0] qz, input logic [15:0] qw,
        input logic [31:0] tx, input logic [31:0] ty, input logic [31:0] tz,
        input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] sz,
        input logic hold
    );
        pose_t p;
        p.qx = qx; p.qy = qy; p.qz = qz; p.qw = qw;
        p.tx = tx; p.ty = ty; p.tz = tz;
        p.sx = sx; p.sy = sy; p.sz = sz;
        p.hold = hold;
        pose_q.push_back(p);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            err_cnt = err_cnt + 1;
            if (err_cnt <= 10)
                $display("mismatch on %s (result %0d): expected %h, got %h",
                         name, got_cnt, exp_v, act_v);
        end
    endtask

    // Driver: predict on each accepted transfer, then present the next pose
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                xform_q.push_back(pose_to_xform(cur_pose));
                sent_cnt = sent_cnt + 1;
            end
            if (!in_valid || in_ready)
            begin
                // hold off a marked pose until every result is back
                if (pose_q.size() != 0
                    && ((sent_cnt >= QUIET_LO && sent_cnt < QUIET_HI)
                        || $urandom_range(0, 99) >= IDLE_PCT)
                    && !(pose_q[0].hold && sent_cnt != got_cnt))
                begin
                    cur_pose = pose_q.pop_front();
                    quat_x   <= cur_pose.qx;
                    quat_y   <= cur_pose.qy;
                    quat_z   <= cur_pose.qz;
                    quat_w   <= cur_pose.qw;
                    trans_x  <= cur_pose.tx;
                    trans_y  <= cur_pose.ty;
                    trans_z  <= cur_pose.tz;
                    scale_x  <= cur_pose.sx;
                    scale_y  <= cur_pose.sy;
                    scale_z  <= cur_pose.sz;
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each output transfer with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got_cnt <= got_cnt + 1;
                if (xform_q.size() == 0)
                begin
                    err_cnt = err_cnt + 1;
                    if (err_cnt <= 10)
                        $display("unexpected result transfer: m_11 %h out_tx %h",
                                 m_11, out_tx);
                end
                else
                begin
                    want = xform_q.pop_front();
                    check_field("m_11", want.m11, m_11);
                    check_field("m_12", want.m12, m_12);
                    check_field("m_13", want.m13, m_13);
                    check_field("m_21", want.m21, m_21);
                    check_field("m_22", want.m22, m_22);
                    check_field("m_23", want.m23, m_23);
                    check_field("m_31", want.m31, m_31);
                    check_field("m_32", want.m32, m_32);
                    check_field("m_33", want.m33, m_33);
                    check_field("out_tx", want.tx, out_tx);
                    check_field("out_ty", want.ty, out_ty);
                    check_field("out_tz", want.tz, out_tz);
                end
            end
            out_ready <= (got_cnt >= QUIET_LO && got_cnt < QUIET_HI)
                         || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Stop a hung run
    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
            @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        pose_t p;

        // zero pose, identity, identity with extreme scales and translations
        add_pose(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0000, 16'h0000, 16'h0000, 1'b0);
        add_pose(16'h0000, 16'h0000, 16'h0000, 16'h4000,
                 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_pose(16'h0000, 16'h0000, 16'h0000, 16'h4000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 16'h8000, 16'h7FFF, 16'hFFFF, 1'b0);
        // all fields at their negative and positive limits
        add_pose(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 16'h8000, 16'h8000, 16'h8000, 1'b0);
        add_pose(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        add_pose(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
                 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                 16'h7FFF, 16'h8000, 16'h0001, 1'b0);
        add_pose(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000,
                 32'h1234_5678, 32'h8765_4321, 32'h0000_0001,
                 16'hFFFF, 16'h0001, 16'h8000, 1'b0);
        // half turns about each axis, negative w
        add_pose(16'h4000, 16'h0000, 16'h0000, 16'h0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_pose(16'h0000, 16'h4000, 16'h0000, 16'h0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0100, 16'h0200, 16'hFF00, 1'b0);
        add_pose(16'h0000, 16'h0000, 16'h4000, 16'h0000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'hFF00, 16'h0100, 16'h0080, 1'b0);
        add_pose(16'h0000, 16'h0000, 16'h0000, 16'hC000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0100, 16'h0100, 16'h0100, 1'b0);
        add_pose(16'h2000, 16'h2000, 16'h2000, 16'h2000,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0100, 16'h0100, 16'h0100, 1'b0);
        // quaternion far from unit length, taken as is
        add_pose(16'd100, -16'sd200, 16'd300, 16'd50,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0200, 16'hFF00, 16'h0080, 1'b0);
        // exact half-way rounding, positive and negative
        add_pose(16'd64, 16'd64, 16'd0, 16'd0,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'd64, 16'd64, 16'd64, 1'b0);
        add_pose(16'd64, 16'd64, 16'd0, 16'd0,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 -16'sd64, -16'sd64, -16'sd64, 1'b0);
        add_pose(16'd0, 16'd0, 16'd64, 16'd64,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'd64, -16'sd64, 16'd64, 1'b0);
        // unit-sized components and alternating bit patterns
        add_pose(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF,
                 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
                 16'h0001, 16'hFFFF, 16'h7FFF, 1'b0);
        add_pose(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        add_pose(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);

        // random poses; a few wait for the pipeline to drain first
        for (int i = 0; i < RAND_POSES; i++)
        begin
            p.qx   = pick16();
            p.qy   = pick16();
            p.qz   = pick16();
            p.qw   = pick16();
            p.tx   = pick32();
            p.ty   = pick32();
            p.tz   = pick32();
            p.sx   = pick16();
            p.sy   = pick16();
            p.sz   = pick16();
            p.hold = (i == 0 || i == 400 || i == 1000);
            pose_q.push_back(p);
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // wait for all poses to go in and all results to come out
        while (pose_q.size() != 0 || in_valid || xform_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (err_cnt == 0 && xform_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
